@@ rtl/orrl_pkg.sv @@
package orrl_pkg;

    localparam int RING_BYTES_DEF = 4096;
    localparam int MAX_RECORD_DEF = 1024;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_BYTE    = 2'd1,
        OP_RESTART = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_NO_ROOM  = 2'd2;
    localparam logic [1:0] ST_SEQ      = 2'd3;

    // queued item, already classified by the front end
    typedef struct packed {
        t_op         op;
        logic [14:0] len;
        logic [7:0]  data;
        logic        over;
    } t_item;

    typedef struct packed {
        logic [12:0] used;
        logic [11:0] count;
        logic        done;
        logic        first;
        logic        last;
        logic [14:0] len;
        logic [7:0]  rbyte;
        logic [1:0]  status;
    } t_result;

endpackage

@@ rtl/orrl_front.sv @@
module orrl_front #(
    parameter int MAX_RECORD = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_op,
    input  logic [14:0]    i_len,
    input  logic [7:0]     i_data,
    output logic           o_item_vld,
    output orrl_pkg::t_item o_item,
    input  logic           i_pop
);
    import orrl_pkg::*;

    t_item      r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_item      w_new;
    logic       w_push;

    assign o_ready    = (r_cnt != 2'd2);
    assign w_push     = i_valid && o_ready;
    assign o_item_vld = (r_cnt != 2'd0);
    assign o_item     = r_q[r_rd];

    always_comb begin
        w_new.op   = t_op'(i_op);
        w_new.len  = i_len;
        w_new.data = i_data;
        w_new.over = (i_len > 15'(MAX_RECORD));
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

endmodule

@@ rtl/orrl_back.sv @@
module orrl_back #(
    parameter int RING_BYTES = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_vld,
    input  orrl_pkg::t_item  i_item,
    output logic             o_pop,
    input  logic             i_cfg_vld,
    input  logic [12:0]      i_cfg_data,
    output logic             o_out_vld,
    output orrl_pkg::t_result o_out,
    input  logic             i_out_ready
);
    import orrl_pkg::*;

    localparam int MW = $clog2(RING_BYTES);
    localparam int PW = $clog2(RING_BYTES + 1);
    localparam int CW = ((PW > 15) ? PW : 15) + 2;
    localparam int IW = PW + 2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_GAP, S_EVICT, S_W_CHK, S_W_RD1, S_W_RD2, S_PUSH_HDR,
        S_HDR_LO, S_HDR_HI, S_R_CHK, S_R_H1, S_R_H2, S_R_BYTE, S_RESP
    } t_state;

    logic [7:0] r_mem [RING_BYTES];
    logic [7:0] r_mem_q;
    logic       r_rd_ok;

    t_state      r_state, n_state;
    logic [PW-1:0] r_clr, n_clr;
    logic [12:0] r_cap_raw, n_cap_raw;
    logic [PW-1:0] r_head, n_head, r_tail, n_tail, r_wp, n_wp, r_hp, n_hp;
    logic [PW-1:0] r_cursor, n_cursor, r_seg_end, n_seg_end, r_rd_head, n_rd_head;
    logic [PW-1:0] r_t, n_t, r_told, n_told, r_hold, n_hold, r_hnew, n_hnew;
    logic [PW-1:0] r_start, n_start, r_gp, n_gp, r_hdr_addr, n_hdr_addr;
    logic [11:0] r_count, n_count;
    logic [14:0] r_rem, n_rem, r_plen, n_plen, r_left, n_left, r_len, n_len;
    logic [14:0] r_ilen, n_ilen;
    logic [1:0]  r_phase, n_phase;
    logic        r_second, n_second, r_in_rec, n_in_rec, r_wrap, n_wrap;
    logic [IW-1:0] r_iter, n_iter;
    logic [7:0]  r_hdr_lo, n_hdr_lo, r_hdr_hi, n_hdr_hi, r_lo, n_lo;
    logic [2:0]  r_pass, n_pass;
    t_result     r_res, n_res, r_out, n_out;
    logic        r_out_vld, n_out_vld;

    logic [PW-1:0] cap;
    logic [7:0]    rdata;
    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [PW-1:0] mem_raddr;
    logic          clearing;

    always_comb begin
        if (r_cap_raw < 13'd3) begin
            cap = PW'(3);
        end else if (CW'(r_cap_raw) > CW'(RING_BYTES)) begin
            cap = PW'(RING_BYTES);
        end else begin
            cap = PW'(r_cap_raw);
        end
    end

    assign rdata     = r_rd_ok ? r_mem_q : 8'd0;
    assign clearing  = (r_state == S_CLEAR);
    assign o_out_vld = r_out_vld;
    assign o_out     = r_out;

    function automatic logic [11:0] sat_inc(input logic [11:0] c);
        return (c == 12'hFFF) ? c : c + 12'd1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (clearing) begin
            r_mem[r_clr[MW-1:0]] <= 8'd0;
        end else if (mem_we && (mem_waddr < cap)) begin
            r_mem[mem_waddr[MW-1:0]] <= mem_wdata;
        end
        r_mem_q <= r_mem[mem_raddr[MW-1:0]];
        r_rd_ok <= (mem_raddr < cap);
    end

    always_comb begin
        logic [CW-1:0] req, hn, t2c, c2, used;
        logic          wrap, in_a, in_b, bad;
        logic [PW-1:0] t2, endv;
        logic [11:0]   cnt;
        logic [14:0]   size;

        n_state = r_state;     n_clr = r_clr;         n_cap_raw = r_cap_raw;
        n_head = r_head;       n_tail = r_tail;       n_wp = r_wp;
        n_hp = r_hp;           n_cursor = r_cursor;   n_seg_end = r_seg_end;
        n_rd_head = r_rd_head; n_t = r_t;             n_told = r_told;
        n_hold = r_hold;       n_hnew = r_hnew;       n_start = r_start;
        n_gp = r_gp;           n_hdr_addr = r_hdr_addr;
        n_count = r_count;     n_rem = r_rem;         n_plen = r_plen;
        n_left = r_left;       n_len = r_len;         n_ilen = r_ilen;
        n_phase = r_phase;     n_second = r_second;   n_in_rec = r_in_rec;
        n_wrap = r_wrap;       n_iter = r_iter;       n_hdr_lo = r_hdr_lo;
        n_hdr_hi = r_hdr_hi;   n_lo = r_lo;           n_pass = r_pass;
        n_res = r_res;         n_out = r_out;         n_out_vld = r_out_vld;
        mem_we = 1'b0;  mem_waddr = r_gp;  mem_wdata = 8'd0;  mem_raddr = r_t;
        o_pop = 1'b0;
        req = '0; hn = '0; t2c = '0; c2 = '0; used = '0;
        wrap = 1'b0; in_a = 1'b0; in_b = 1'b0; bad = 1'b0;
        t2 = '0; endv = '0; cnt = r_count; size = '0;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == PW'(RING_BYTES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + PW'(1);
                end
            end
            S_IDLE: begin
                if (i_item_vld) begin
                    o_pop  = 1'b1;
                    n_res  = '0;
                    n_ilen = i_item.len;
                    n_state = S_RESP;
                    unique case (i_item.op)
                        OP_PUSH: begin
                            req = CW'(i_item.len) + CW'(2);
                            if (r_rem != 15'd0) begin
                                n_res.status = ST_SEQ;
                            end else if (i_item.over) begin
                                n_res.status = ST_TOO_LONG;
                            end else if (req > CW'(cap)) begin
                                n_res.status = ST_NO_ROOM;
                            end else begin
                                n_phase = 2'd0;
                                wrap    = (CW'(r_head) + req) > CW'(cap);
                                hn      = (wrap ? CW'(0) : CW'(r_head)) + req;
                                n_wrap  = wrap;
                                n_start = wrap ? PW'(0) : r_head;
                                n_hnew  = hn[PW-1:0];
                                n_head  = hn[PW-1:0];
                                n_hold  = r_head;
                                n_told  = r_tail;
                                n_gp    = r_head;
                                n_state = (wrap && (cap > r_head)) ? S_GAP : S_EVICT;
                            end
                        end
                        OP_BYTE: begin
                            if (r_rem == 15'd0) begin
                                n_res.status = ST_SEQ;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_wp;
                                mem_wdata = i_item.data;
                                n_wp  = r_wp + PW'(1);
                                n_rem = r_rem - 15'd1;
                                if (r_rem == 15'd1) begin
                                    n_hdr_addr = r_hp;
                                    n_hdr_lo   = r_plen[7:0];
                                    n_hdr_hi   = {1'b1, r_plen[14:8]};
                                    n_state    = S_HDR_LO;
                                end
                            end
                        end
                        OP_RESTART: begin
                            n_in_rec = 1'b0;
                            if (r_count == 12'd0) begin
                                n_phase    = 2'd0;
                                n_res.done = 1'b1;
                            end else begin
                                n_rd_head = r_head;
                                n_cursor  = r_tail;
                                if (r_tail < r_head) begin
                                    n_seg_end = r_head;
                                    n_second  = 1'b0;
                                end else begin
                                    n_seg_end = cap;
                                    n_second  = 1'b1;
                                end
                                n_phase = 2'd1;
                            end
                        end
                        OP_READ: begin
                            n_pass  = 3'd0;
                            n_state = S_R_CHK;
                        end
                    endcase
                end
            end
            S_GAP: begin
                // zero the unused end of the ring before wrapping
                mem_we    = 1'b1;
                mem_waddr = r_gp;
                if (r_gp + PW'(1) == cap) begin
                    n_state = S_EVICT;
                end else begin
                    n_gp = r_gp + PW'(1);
                end
            end
            S_EVICT: begin
                if (r_hold == '0 && r_told == '0) begin
                    n_count = 12'd1;
                    n_state = S_PUSH_HDR;
                end else begin
                    n_t     = r_told;
                    n_iter  = '0;
                    n_state = S_W_CHK;
                end
            end
            S_W_CHK: begin
                in_a = (r_t >= r_start) && (r_t < r_hnew);
                in_b = r_wrap && (r_t >= r_hold) && (r_t < cap);
                if (!in_a && !in_b) begin
                    n_tail  = r_t;
                    n_count = sat_inc(r_count);
                    n_state = S_PUSH_HDR;
                end else if (CW'(r_iter) > ((CW'(cap) << 1) + CW'(4))) begin
                    n_tail  = r_hnew;
                    n_count = sat_inc(r_count);
                    n_state = S_PUSH_HDR;
                end else begin
                    mem_raddr = r_t;
                    n_state   = S_W_RD1;
                end
            end
            S_W_RD1: begin
                n_lo      = rdata;
                mem_raddr = r_t + PW'(1);
                n_state   = S_W_RD2;
            end
            S_W_RD2: begin
                size = {rdata[6:0], r_lo};
                if (rdata[7] && size != 15'd0) begin
                    t2c = CW'(r_t) + CW'(2) + CW'(size);
                    t2  = (t2c >= CW'(cap)) ? PW'(0) : t2c[PW-1:0];
                    if (cnt != 12'd0) begin
                        cnt = cnt - 12'd1;
                    end
                end else begin
                    t2 = (r_wrap && r_t >= r_hold) ? PW'(0) : r_hnew;
                end
                n_count = cnt;
                if (t2 == r_told) begin
                    n_tail  = r_hnew;
                    n_count = sat_inc(cnt);
                    n_state = S_PUSH_HDR;
                end else begin
                    n_t     = t2;
                    n_iter  = r_iter + IW'(1);
                    n_state = S_W_CHK;
                end
            end
            S_PUSH_HDR: begin
                n_hp       = r_start;
                n_wp       = r_start + PW'(2);
                n_rem      = r_ilen;
                n_plen     = r_ilen;
                n_hdr_addr = r_start;
                n_hdr_lo   = 8'd0;
                n_hdr_hi   = (r_ilen == 15'd0) ? 8'h80 : 8'h00;
                n_state    = S_HDR_LO;
            end
            S_HDR_LO: begin
                mem_we    = 1'b1;
                mem_waddr = r_hdr_addr;
                mem_wdata = r_hdr_lo;
                n_state   = S_HDR_HI;
            end
            S_HDR_HI: begin
                mem_we    = 1'b1;
                mem_waddr = r_hdr_addr + PW'(1);
                mem_wdata = r_hdr_hi;
                n_state   = S_RESP;
            end
            S_R_CHK: begin
                if (r_in_rec) begin
                    mem_raddr = r_cursor;
                    n_state   = S_R_BYTE;
                end else if (r_pass == 3'd4) begin
                    n_phase    = 2'd0;
                    n_res.done = 1'b1;
                    n_state    = S_RESP;
                end else if (r_phase == 2'd0) begin
                    n_res.done = 1'b1;
                    n_state    = S_RESP;
                end else begin
                    mem_raddr = r_cursor;
                    n_state   = S_R_H1;
                end
            end
            S_R_H1: begin
                n_lo      = rdata;
                mem_raddr = r_cursor + PW'(1);
                n_state   = S_R_H2;
            end
            S_R_H2: begin
                size = {rdata[6:0], r_lo};
                endv = (r_phase == 2'd1) ? r_seg_end : r_rd_head;
                c2   = CW'(r_cursor) + CW'(2);
                bad  = (c2 > CW'(endv)) || !rdata[7] || ((c2 + CW'(size)) > CW'(endv));
                if (bad) begin
                    if (r_phase == 2'd1 && r_second) begin
                        n_phase  = 2'd2;
                        n_cursor = '0;
                        n_pass   = r_pass + 3'd1;
                        n_state  = S_R_CHK;
                    end else begin
                        n_phase    = 2'd0;
                        n_res.done = 1'b1;
                        n_state    = S_RESP;
                    end
                end else begin
                    n_cursor = r_cursor + PW'(2);
                    n_len    = size;
                    if (size == 15'd0) begin
                        n_res.first = 1'b1;
                        n_res.last  = 1'b1;
                        n_state     = S_RESP;
                    end else begin
                        n_left   = size;
                        n_in_rec = 1'b1;
                        n_pass   = r_pass + 3'd1;
                        n_state  = S_R_CHK;
                    end
                end
            end
            S_R_BYTE: begin
                n_res.rbyte = rdata;
                n_res.len   = r_len;
                n_res.first = (r_left == r_len);
                n_res.last  = (r_left == 15'd1);
                n_cursor    = r_cursor + PW'(1);
                n_left      = r_left - 15'd1;
                if (r_left == 15'd1) begin
                    n_in_rec = 1'b0;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_vld || i_out_ready) begin
                    if (r_count == 12'd0) begin
                        used = '0;
                    end else if (r_head > r_tail) begin
                        used = CW'(r_head) - CW'(r_tail);
                    end else begin
                        used = CW'(cap) - CW'(r_tail) + CW'(r_head);
                    end
                    n_out       = r_res;
                    n_out.count = r_count;
                    n_out.used  = used[12:0];
                    n_out_vld   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // a capacity write re-initialises the whole log
        if (i_cfg_vld) begin
            n_cap_raw = i_cfg_data;
            n_state   = S_CLEAR;
            n_clr     = '0;
            n_head = '0; n_tail = '0; n_count = '0; n_wp = '0; n_rem = '0; n_hp = '0;
            n_cursor = '0; n_phase = '0; n_seg_end = '0; n_rd_head = '0;
            n_left = '0; n_len = '0; n_second = 1'b0; n_in_rec = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_cap_raw <= 13'd4096;
            r_head    <= '0;  r_tail  <= '0;  r_count <= '0;
            r_wp      <= '0;  r_rem   <= '0;  r_hp    <= '0;
            r_cursor  <= '0;  r_phase <= '0;  r_seg_end <= '0;
            r_rd_head <= '0;  r_left  <= '0;  r_len   <= '0;
            r_second  <= 1'b0; r_in_rec <= 1'b0;
            r_out_vld <= 1'b0;
            r_pass    <= '0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_cap_raw <= n_cap_raw;
            r_head    <= n_head;  r_tail  <= n_tail;  r_count <= n_count;
            r_wp      <= n_wp;    r_rem   <= n_rem;   r_hp    <= n_hp;
            r_cursor  <= n_cursor; r_phase <= n_phase; r_seg_end <= n_seg_end;
            r_rd_head <= n_rd_head; r_left <= n_left;  r_len   <= n_len;
            r_second  <= n_second; r_in_rec <= n_in_rec;
            r_out_vld <= n_out_vld;
            r_pass    <= n_pass;
        end
        r_t <= n_t;  r_told <= n_told;  r_hold <= n_hold;  r_hnew <= n_hnew;
        r_start <= n_start;  r_gp <= n_gp;  r_hdr_addr <= n_hdr_addr;
        r_plen <= n_plen;  r_ilen <= n_ilen;  r_wrap <= n_wrap;  r_iter <= n_iter;
        r_hdr_lo <= n_hdr_lo;  r_hdr_hi <= n_hdr_hi;  r_lo <= n_lo;
        r_res <= n_res;  r_out <= n_out;
    end

endmodule

@@ rtl/overwriting_record_ring_log_core.sv @@
// channel   | direction | handshake                      | contents
// s_axis    | in        | s_axis_tvalid / s_axis_tready  | operation, length, payload byte
// m_axis    | out       | m_axis_tvalid / m_axis_tready  | status, read byte, counters
// cfg       | in        | i_cfg_valid / o_cfg_ready      | ring capacity
//
// One item at a time. Refused pushes, stray or plain payload bytes and restarts go
// straight to the result; the byte that completes a record then rewrites its header, low
// then high. A read returns the next byte, checking headers first when between records,
// or reports done. An accepted push zeroes any gap bytes, steps over the headers it
// overwrites unless the log is empty, then writes its header. The next item is taken as
// the result becomes valid. A clear sweep over all RING_BYTES bytes follows reset and
// every capacity write. Input is queued two deep; a stalled result holds the back end.
module overwriting_record_ring_log_core #(
    parameter int RING_BYTES = orrl_pkg::RING_BYTES_DEF,
    parameter int MAX_RECORD = orrl_pkg::MAX_RECORD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // record_length[14:0], payload_byte[22:15]
    input  logic [1:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_byte[7:0], read_record_length[22:8], first_of_record[23],
    // readout_done[24], record_count[36:25], bytes_used[49:37]
    output logic [55:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast,   // last_of_record
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data
);
    import orrl_pkg::*;

    t_item   w_item;
    logic    w_item_vld;
    logic    w_pop;
    t_result w_out;

    assign o_cfg_ready = 1'b1;

    orrl_front #(
        .MAX_RECORD (MAX_RECORD)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_op       (s_axis_tuser),
        .i_len      (s_axis_tdata[14:0]),
        .i_data     (s_axis_tdata[22:15]),
        .o_item_vld (w_item_vld),
        .o_item     (w_item),
        .i_pop      (w_pop)
    );

    orrl_back #(
        .RING_BYTES (RING_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_vld  (w_item_vld),
        .i_item      (w_item),
        .o_pop       (w_pop),
        .i_cfg_vld   (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_vld   (m_axis_tvalid),
        .o_out       (w_out),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {6'd0, w_out.used, w_out.count, w_out.done, w_out.first,
                           w_out.len, w_out.rbyte};
    assign m_axis_tuser = w_out.status;
    assign m_axis_tlast = w_out.last;

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_item_vld) else $error("pop from empty queue");

    a_empty_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_out.count == 12'd0) |-> (w_out.used == 13'd0))
        else $error("bytes reported on empty log");

    a_done_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_out.done) |-> (w_out.rbyte == 8'd0 && !w_out.first))
        else $error("data with readout done");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(w_out.used) <= RING_BYTES))
        else $error("bytes used beyond ring");

endmodule
